// ===== design/ioct_pkg.sv =====
// Shared constants, state encoding and controller/datapath interface types.
`default_nettype none

package ioct_pkg;

	localparam int RING_DEPTH_LOG2 = 10;
	localparam int RING_SIZE       = 1 << RING_DEPTH_LOG2;
	localparam int POS_W           = 64;
	localparam int IDX_W           = RING_DEPTH_LOG2;
	localparam int STEP_W          = RING_DEPTH_LOG2 + 1;

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [5:0] {
		ST_CLEAR   = 6'b000001,
		ST_IDLE    = 6'b000010,
		ST_CHECK   = 6'b000100,
		ST_COMPARE = 6'b001000,
		ST_DONE    = 6'b010000,
		ST_SPARE   = 6'b100000
	} state_t;

	typedef struct packed {
		logic clear;       // write zero at the sweep index and advance it
		logic load_pos;    // capture the incoming completion
		logic first_step;  // pointer matched: advance once and read the next slot
		logic walk_step;   // slot compared greater: advance again and read on
		logic store;       // remember an out-of-order completion in its slot
		logic load_out;    // move the result into the output register
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic pos_match;
		logic walk_more;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

// ===== design/ioct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ioct_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== design/ioct_ctrl.sv =====
// Controller state machine: clearing sweep, accept, match check, pointer walk, result hand-off.
`default_nettype none

module ioct_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire ioct_pkg::status_t status,
	output ioct_pkg::cmd_t         cmd
);

	import ioct_pkg::*;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_pos = 1'b1;
					state_d      = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (status.pos_match) begin
					cmd.first_step = 1'b1;
					state_d        = ST_COMPARE;
				end else begin
					cmd.store = 1'b1;
					state_d   = ST_DONE;
				end
			end
			ST_COMPARE: begin
				if (status.walk_more) begin
					cmd.walk_step = 1'b1;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	a_check_miss_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK && !status.pos_match |=> state_q == ST_DONE)
		else $error("unmatched completion did not go straight to result");

	a_walk_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_COMPARE && !status.walk_more |=> state_q == ST_DONE)
		else $error("pointer walk did not stop");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && !status.out_free |=> state_q == ST_DONE)
		else $error("result dropped while output register full");

endmodule

`default_nettype wire

// ===== design/ioct_dp.sv =====
// Datapath: pointer, captured completion, walk counter, ring memory, output register.
`default_nettype none

module ioct_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ioct_pkg::cmd_t cmd,
	output ioct_pkg::status_t   status,
	input  wire ioct_pkg::pos_t completed_position,
	output logic                out_valid,
	input  wire logic           out_ready,
	output ioct_pkg::pos_t      acked_position,
	output logic                advanced
);

	import ioct_pkg::*;

	pos_t  ptr_q;
	pos_t  pos_q;
	step_t steps_q;
	idx_t  clr_idx_q;
	logic  moved_q;
	logic  out_valid_q;
	pos_t  out_pos_q;
	logic  out_adv_q;

	pos_t  ptr_inc;
	pos_t  ram_rdata;
	logic  ram_we;
	logic  ram_re;
	idx_t  ram_waddr;
	pos_t  ram_wdata;

	assign ptr_inc   = ptr_q + POS_W'(1);
	assign ram_we    = cmd.clear | cmd.store;
	assign ram_waddr = cmd.clear ? clr_idx_q : pos_q[IDX_W-1:0];
	assign ram_wdata = cmd.clear ? '0 : pos_q;
	assign ram_re    = cmd.first_step | cmd.walk_step;

	ioct_ram #(
		.WIDTH (POS_W),
		.DEPTH (RING_SIZE)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ptr_inc[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign status.clear_last = &clr_idx_q;
	assign status.pos_match  = (pos_q == ptr_q);
	assign status.walk_more  = (ram_rdata > pos_q) && (steps_q < STEP_W'(RING_SIZE));
	assign status.out_free   = !out_valid_q || out_ready;

	// Hold the completion, count the walk steps and capture the output result.
	always_ff @(posedge clk) begin
		if (cmd.load_pos) begin
			pos_q <= completed_position;
		end
		if (cmd.first_step) begin
			steps_q <= STEP_W'(1);
		end else if (cmd.walk_step) begin
			steps_q <= steps_q + STEP_W'(1);
		end
		if (cmd.load_out) begin
			out_pos_q <= ptr_q;
			out_adv_q <= moved_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			clr_idx_q   <= '0;
			moved_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.first_step || cmd.walk_step) begin
				ptr_q <= ptr_inc;
			end
			if (cmd.clear) begin
				clr_idx_q <= clr_idx_q + IDX_W'(1);
			end
			if (cmd.first_step) begin
				moved_q <= 1'b1;
			end else if (cmd.store) begin
				moved_q <= 1'b0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign acked_position = out_pos_q;
	assign advanced       = out_adv_q;

	a_ram_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && ram_re))
		else $error("ring written and read in the same cycle");

	a_ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.first_step && !cmd.walk_step |=> $stable(ptr_q))
		else $error("pointer moved outside a walk step");

	a_load_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !out_valid_q || out_ready)
		else $error("result loaded over an untaken result");

	a_store_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> !status.pos_match)
		else $error("matching completion written to the ring");

endmodule

`default_nettype wire

// ===== design/in_order_completion_tracker.sv =====
// Top level of the in-order completion tracker: controller plus datapath.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------
//  in       | in_valid/in_ready  | completed_position[63:0]
//  out      | out_valid/out_ready| acked_position[63:0], advanced
//
//  After reset the ring is swept to zero, one slot per cycle, with in_ready
//  low until all 1024 slots have been cleared.
//  An out-of-order completion goes from transfer to result load through
//  accept, compare with the pointer plus ring write, and result.
//  A completion matching the pointer goes through accept, match check, a
//  walk of k positions (1..1024) and result; each walk step is one registered
//  ring read compared in the following cycle, which sets the walk rate.
//  The output register holds a result while out_ready is low; the next input
//  transfer is still taken, and the controller waits in its done state until the output is free.
`default_nettype none

module in_order_completion_tracker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [ioct_pkg::POS_W-1:0] completed_position,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic      [ioct_pkg::POS_W-1:0] acked_position,
	output logic                            advanced
);

	import ioct_pkg::*;

	// Commands flow controller to datapath; status flows back.
	cmd_t    cmd;
	status_t status;

	ioct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// Pointer, ring and output register live in the datapath.
	ioct_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.completed_position (completed_position),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.acked_position     (acked_position),
		.advanced           (advanced)
	);

endmodule

`default_nettype wire
